### design/rational_arithmetic_unit_assert.svh
// Assertion macros shared by the rational arithmetic unit modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rau_pkg.sv
package rau_pkg;

  // Result field width
  localparam int OUT_W = 33;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Top-level sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A_GO,
    S_RED_A,
    S_RED_B_GO,
    S_RED_B,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_RED_R_GO,
    S_RED_R,
    S_OUT
  } top_state_t;

  // Reduction sequencer
  typedef enum logic [3:0] {
    R_IDLE,
    R_SH,
    R_XO,
    R_LOOP,
    R_DN_GO,
    R_DN_WAIT,
    R_DD_GO,
    R_DD_WAIT,
    R_DONE
  } red_state_t;

  typedef struct packed {
    logic start;
  } red_ctl_t;

  typedef struct packed {
    logic done;
    logic err;
  } red_sts_t;

endpackage

### design/rau_if.sv
interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [rau_pkg::OUT_W-1:0] res_num;
  logic signed [rau_pkg::OUT_W-1:0] res_den;
  logic                            status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### design/rau_div.sv
`include "rational_arithmetic_unit_assert.svh"

module rau_div #(
  parameter int RW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] dvd,
  input  logic [RW-1:0] dvs,
  output logic          done,
  output logic [RW-1:0] quotient
);

  localparam int CW = $clog2(RW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW:0]   rem_r, rem_nxt;
  logic [RW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] dvs_r, dvs_nxt;
  logic [RW:0]   trial;
  logic          ge;

  // Shift in the next dividend bit and try the divisor
  assign trial = {rem_r[RW-1:0], quo_r[RW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RW - 1);
      rem_nxt  = '0;
      quo_nxt  = dvd;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt = {quo_r[RW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `RAU_ASSERT_SAME(a_div_rem_below_dvs, busy_r, rem_r < {1'b0, dvs_r}, "remainder not below divisor")
  `RAU_ASSERT_SAME(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule

### design/rau_reduce.sv
`include "rational_arithmetic_unit_assert.svh"

module rau_reduce #(
  parameter int RW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::red_ctl_t    ctl,
  input  logic signed [RW-1:0] num,
  input  logic signed [RW-1:0] den,
  output rau_pkg::red_sts_t    sts,
  output logic signed [RW-1:0] q_num,
  output logic signed [RW-1:0] q_den
);

  localparam int SW = $clog2(RW);

  rau_pkg::red_state_t state_r, state_nxt;

  logic [RW-1:0] x_r, x_nxt;
  logic [RW-1:0] y_r, y_nxt;
  logic [RW-1:0] mn_r, mn_nxt;
  logic [RW-1:0] md_r, md_nxt;
  logic [RW-1:0] g_r, g_nxt;
  logic [SW-1:0] sh_r, sh_nxt;
  logic          n_neg_r, n_neg_nxt;
  logic          d_neg_r, d_neg_nxt;
  logic          err_r, err_nxt;
  logic signed [RW-1:0] q_num_r, q_num_nxt;
  logic signed [RW-1:0] q_den_r, q_den_nxt;

  logic [RW-1:0] mag_n, mag_d;
  logic          den_zero, num_zero;
  logic          div_start, div_done;
  logic [RW-1:0] div_dvd, div_quo;

  // Magnitudes of the incoming fraction
  assign mag_n    = num[RW-1] ? (~num + 1'b1) : num;
  assign mag_d    = den[RW-1] ? (~den + 1'b1) : den;
  assign den_zero = (den == '0);
  assign num_zero = (num == '0);

  // Divide both magnitudes by the gcd, one after the other
  assign div_start = (state_r == rau_pkg::R_DN_GO) || (state_r == rau_pkg::R_DD_GO);
  assign div_dvd   = (state_r == rau_pkg::R_DN_GO) ? mn_r : md_r;

  rau_div #(.RW(RW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dvd      (div_dvd),
    .dvs      (g_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::R_IDLE: begin
        if (ctl.start) begin
          if (den_zero || num_zero) state_nxt = rau_pkg::R_DONE;
          else                      state_nxt = rau_pkg::R_SH;
        end
      end
      rau_pkg::R_SH: begin
        if (x_r[0] || y_r[0]) state_nxt = rau_pkg::R_XO;
      end
      rau_pkg::R_XO: begin
        if (x_r[0]) state_nxt = rau_pkg::R_LOOP;
      end
      rau_pkg::R_LOOP: begin
        if (y_r == '0) state_nxt = rau_pkg::R_DN_GO;
      end
      rau_pkg::R_DN_GO:   state_nxt = rau_pkg::R_DN_WAIT;
      rau_pkg::R_DN_WAIT: begin
        if (div_done) state_nxt = rau_pkg::R_DD_GO;
      end
      rau_pkg::R_DD_GO:   state_nxt = rau_pkg::R_DD_WAIT;
      rau_pkg::R_DD_WAIT: begin
        if (div_done) state_nxt = rau_pkg::R_DONE;
      end
      rau_pkg::R_DONE:    state_nxt = rau_pkg::R_IDLE;
      default:            state_nxt = rau_pkg::R_IDLE;
    endcase
  end

  // Binary gcd datapath and signed quotients
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    mn_nxt    = mn_r;
    md_nxt    = md_r;
    g_nxt     = g_r;
    sh_nxt    = sh_r;
    n_neg_nxt = n_neg_r;
    d_neg_nxt = d_neg_r;
    err_nxt   = err_r;
    q_num_nxt = q_num_r;
    q_den_nxt = q_den_r;
    case (state_r)
      rau_pkg::R_IDLE: begin
        if (ctl.start) begin
          n_neg_nxt = num[RW-1];
          d_neg_nxt = den[RW-1];
          x_nxt     = mag_n;
          y_nxt     = mag_d;
          mn_nxt    = mag_n;
          md_nxt    = mag_d;
          sh_nxt    = '0;
          err_nxt   = den_zero;
          // zero numerator becomes 0/1, zero denominator 0/0
          q_num_nxt = '0;
          q_den_nxt = {{(RW-1){1'b0}}, ~den_zero};
        end
      end
      rau_pkg::R_SH: begin
        if (!(x_r[0] || y_r[0])) begin
          x_nxt  = x_r >> 1;
          y_nxt  = y_r >> 1;
          sh_nxt = sh_r + 1'b1;
        end
      end
      rau_pkg::R_XO: begin
        if (!x_r[0]) x_nxt = x_r >> 1;
      end
      rau_pkg::R_LOOP: begin
        if (y_r == '0) begin
          g_nxt = x_r << sh_r;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r > y_r) begin
          x_nxt = y_r;
          y_nxt = x_r - y_r;
        end else begin
          y_nxt = y_r - x_r;
        end
      end
      rau_pkg::R_DN_WAIT: begin
        if (div_done) q_num_nxt = n_neg_r ? (~div_quo + 1'b1) : div_quo;
      end
      rau_pkg::R_DD_WAIT: begin
        if (div_done) q_den_nxt = d_neg_r ? (~div_quo + 1'b1) : div_quo;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    mn_r    <= mn_nxt;
    md_r    <= md_nxt;
    g_r     <= g_nxt;
    sh_r    <= sh_nxt;
    n_neg_r <= n_neg_nxt;
    d_neg_r <= d_neg_nxt;
    err_r   <= err_nxt;
    q_num_r <= q_num_nxt;
    q_den_r <= q_den_nxt;
  end

  assign sts.done = (state_r == rau_pkg::R_DONE);
  assign sts.err  = err_r;
  assign q_num    = q_num_r;
  assign q_den    = q_den_r;

  `RAU_ASSERT_SAME(a_red_x_nonzero, state_r == rau_pkg::R_LOOP, x_r != '0, "gcd operand x is zero")
  `RAU_ASSERT_NEXT(a_red_done_pulse, sts.done, !sts.done, "reduction done held longer than a cycle")

endmodule

### design/rational_arithmetic_unit.sv
// Sequence: three reductions (operand a, operand b, result), with the multiply states
// S_MUL1-S_MUL4 before the last; a zero denominator in a or b ends the request there.
// Each reduction is a binary gcd of shift/subtract steps and two restoring divisions;
// RW = 2*OPERAND_WIDTH+1 capped at 64. A zero numerator or denominator skips the gcd and
// both divisions. Throughput: one request at a time; in_ready returns as the result is
// registered. Reset clears the sequencers and the output valid flag; no clearing pass.
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic   clk,
  input logic   rst_n,
  rau_in_if.sink    in_if,
  rau_out_if.source out_if
);

  localparam int W  = OPERAND_WIDTH;
  localparam int RW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int OW = rau_pkg::OUT_W;

  rau_pkg::top_state_t state_r, state_nxt;

  logic [1:0]            op_r, op_nxt;
  logic signed [W-1:0]   an_r, an_nxt;
  logic signed [W-1:0]   ad_r, ad_nxt;
  logic signed [W-1:0]   bn_r, bn_nxt;
  logic signed [W-1:0]   bd_r, bd_nxt;
  logic signed [2*W-1:0] prod_r, prod_nxt;
  logic signed [RW-1:0]  rn_r, rn_nxt;
  logic signed [RW-1:0]  rd_r, rd_nxt;
  logic                  err_r, err_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]  res_num_r, res_num_nxt;
  logic signed [OW-1:0]  res_den_r, res_den_nxt;
  logic                  status_r, status_nxt;

  logic                  accept, load;
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] mul_p;
  logic signed [63:0]    rn_ext, rd_ext;

  rau_pkg::red_ctl_t    red_ctl;
  rau_pkg::red_sts_t    red_sts;
  logic signed [RW-1:0] red_num, red_den;
  logic signed [RW-1:0] red_q_num, red_q_den;

  assign accept = in_if.valid && (state_r == rau_pkg::S_IDLE);
  assign load   = (state_r == rau_pkg::S_OUT) && (!out_valid_r || out_if.ready);

  // Shared reduction unit, fed operand a, operand b, then the raw result
  assign red_ctl.start = (state_r == rau_pkg::S_RED_A_GO) ||
                         (state_r == rau_pkg::S_RED_B_GO) ||
                         (state_r == rau_pkg::S_RED_R_GO);

  always_comb begin
    red_num = rn_r;
    red_den = rd_r;
    case (state_r)
      rau_pkg::S_RED_A_GO: begin
        red_num = RW'(an_r);
        red_den = RW'(ad_r);
      end
      rau_pkg::S_RED_B_GO: begin
        red_num = RW'(bn_r);
        red_den = RW'(bd_r);
      end
      default: begin
        red_num = rn_r;
        red_den = rd_r;
      end
    endcase
  end

  rau_reduce #(.RW(RW)) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (red_ctl),
    .num   (red_num),
    .den   (red_den),
    .sts   (red_sts),
    .q_num (red_q_num),
    .q_den (red_q_den)
  );

  // Shared multiplier operand selection
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      rau_pkg::S_MUL1: begin
        mul_a = an_r;
        mul_b = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
      end
      rau_pkg::S_MUL2: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      rau_pkg::S_MUL3: begin
        mul_a = ad_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_if.valid) state_nxt = rau_pkg::S_RED_A_GO;
      end
      rau_pkg::S_RED_A_GO: state_nxt = rau_pkg::S_RED_A;
      rau_pkg::S_RED_A: begin
        if (red_sts.done) state_nxt = red_sts.err ? rau_pkg::S_OUT : rau_pkg::S_RED_B_GO;
      end
      rau_pkg::S_RED_B_GO: state_nxt = rau_pkg::S_RED_B;
      rau_pkg::S_RED_B: begin
        if (red_sts.done) state_nxt = red_sts.err ? rau_pkg::S_OUT : rau_pkg::S_MUL1;
      end
      rau_pkg::S_MUL1:     state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:     state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3:     state_nxt = rau_pkg::S_MUL4;
      rau_pkg::S_MUL4:     state_nxt = rau_pkg::S_RED_R_GO;
      rau_pkg::S_RED_R_GO: state_nxt = rau_pkg::S_RED_R;
      rau_pkg::S_RED_R: begin
        if (red_sts.done) state_nxt = rau_pkg::S_OUT;
      end
      rau_pkg::S_OUT: begin
        if (load) state_nxt = rau_pkg::S_IDLE;
      end
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // Datapath: capture, reduced operands, cross products
  always_comb begin
    op_nxt   = op_r;
    an_nxt   = an_r;
    ad_nxt   = ad_r;
    bn_nxt   = bn_r;
    bd_nxt   = bd_r;
    prod_nxt = prod_r;
    rn_nxt   = rn_r;
    rd_nxt   = rd_r;
    err_nxt  = err_r;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt  = in_if.req_type;
          an_nxt  = in_if.a_num;
          ad_nxt  = in_if.a_den;
          bn_nxt  = in_if.b_num;
          bd_nxt  = in_if.b_den;
          err_nxt = 1'b0;
        end
      end
      rau_pkg::S_RED_A: begin
        if (red_sts.done) begin
          an_nxt  = red_q_num[W-1:0];
          ad_nxt  = red_q_den[W-1:0];
          err_nxt = red_sts.err;
        end
      end
      rau_pkg::S_RED_B: begin
        if (red_sts.done) begin
          bn_nxt  = red_q_num[W-1:0];
          bd_nxt  = red_q_den[W-1:0];
          err_nxt = red_sts.err;
        end
      end
      rau_pkg::S_MUL1: begin
        prod_nxt = mul_p;
      end
      rau_pkg::S_MUL2: begin
        rn_nxt   = RW'(prod_r);
        prod_nxt = mul_p;
      end
      rau_pkg::S_MUL3: begin
        if (op_r == rau_pkg::OP_ADD)      rn_nxt = rn_r + RW'(prod_r);
        else if (op_r == rau_pkg::OP_SUB) rn_nxt = rn_r - RW'(prod_r);
        prod_nxt = mul_p;
      end
      rau_pkg::S_MUL4: begin
        rd_nxt = RW'(prod_r);
      end
      rau_pkg::S_RED_R: begin
        if (red_sts.done) begin
          rn_nxt  = red_q_num;
          rd_nxt  = red_q_den;
          err_nxt = red_sts.err;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  assign rn_ext = 64'(rn_r);
  assign rd_ext = 64'(rd_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    status_nxt    = status_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      status_nxt    = err_r;
      res_num_nxt   = err_r ? '0 : rn_ext[OW-1:0];
      res_den_nxt   = err_r ? '0 : rd_ext[OW-1:0];
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    prod_r    <= prod_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    err_r     <= err_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
  end

  assign in_if.ready    = (state_r == rau_pkg::S_IDLE);
  assign out_if.valid   = out_valid_r;
  assign out_if.res_num = res_num_r;
  assign out_if.res_den = res_den_r;
  assign out_if.status  = status_r;

  `RAU_ASSERT_SAME(a_top_err_zero, out_valid_r && status_r, (res_num_r == '0) && (res_den_r == '0), "error result carries nonzero fields")
  `RAU_ASSERT_SAME(a_top_red_done_expected, red_sts.done, (state_r == rau_pkg::S_RED_A) || (state_r == rau_pkg::S_RED_B) || (state_r == rau_pkg::S_RED_R), "reduction finished outside a wait state")

endmodule
